// ===== rtl/rgfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgfd_pkg
// Types, command codes, glyph table and helpers for the glyph drawer.
// ----------------------------------------------------------------------------
package rgfd_pkg;

  localparam int PANEL_COLUMNS = 128;
  localparam int PANEL_PAGES   = 8;
  localparam int STORE_DEPTH   = PANEL_COLUMNS * PANEL_PAGES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int COL_W         = $clog2(PANEL_COLUMNS);
  localparam int PAGE_W        = $clog2(PANEL_PAGES);

  localparam logic [2:0] GLYPH_COLS  = 3'd5;
  localparam logic [2:0] GLYPH_ROWS  = 3'd7;
  localparam logic [2:0] GLYPH_PITCH = 3'd6;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_RECT  = 3'd2;
  localparam logic [2:0] CMD_VCHAR = 3'd3;
  localparam logic [2:0] CMD_PCHAR = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       ink_on;
    logic [7:0] char_code;
    logic [7:0] scale;
    logic [7:0] page;
    logic [7:0] column;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fitted;
    logic [7:0] next_pos;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_WALK, ST_MODIFY, ST_PAGE, ST_READ, ST_READ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic walk_read;
    logic walk_write;
    logic walk_step;
    logic page_write;
    logic read_issue;
    logic read_capture;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       clr_last;
    logic       walk_done;
    logic       walk_need;
    logic       page_fit;
    logic       page_last;
    logic       slot_free;
  } dp_status_t;

  function automatic logic [5:0] rom_slot(input logic [7:0] code);
    logic [5:0] slot;
    slot = 6'd0;
    if (code >= 8'h30 && code <= 8'h39) slot = 6'(code - 8'h30) + 6'd1;
    else if (code >= 8'h41 && code <= 8'h5a) slot = 6'(code - 8'h41) + 6'd11;
    else if (code == 8'h2d) slot = 6'd37;
    else if (code == 8'h2e) slot = 6'd38;
    else if (code == 8'h2b) slot = 6'd39;
    return slot;
  endfunction

  // five columns packed low column first
  function automatic logic [39:0] glyph_row(input logic [5:0] slot);
    logic [39:0] g;
    case (slot)
      6'd1:  g = {8'h3e, 8'h45, 8'h49, 8'h51, 8'h3e};
      6'd2:  g = {8'h00, 8'h40, 8'h7f, 8'h42, 8'h00};
      6'd3:  g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      6'd4:  g = {8'h31, 8'h4b, 8'h45, 8'h41, 8'h21};
      6'd5:  g = {8'h10, 8'h7f, 8'h12, 8'h14, 8'h18};
      6'd6:  g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      6'd7:  g = {8'h30, 8'h49, 8'h49, 8'h4a, 8'h3c};
      6'd8:  g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      6'd9:  g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd10: g = {8'h1e, 8'h29, 8'h49, 8'h49, 8'h06};
      6'd11: g = {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
      6'd12: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7f};
      6'd13: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3e};
      6'd14: g = {8'h1c, 8'h22, 8'h41, 8'h41, 8'h7f};
      6'd15: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7f};
      6'd16: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7f};
      6'd17: g = {8'h7a, 8'h49, 8'h49, 8'h41, 8'h3e};
      6'd18: g = {8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f};
      6'd19: g = {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
      6'd20: g = {8'h01, 8'h3f, 8'h41, 8'h40, 8'h20};
      6'd21: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7f};
      6'd22: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7f};
      6'd23: g = {8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f};
      6'd24: g = {8'h7f, 8'h10, 8'h08, 8'h04, 8'h7f};
      6'd25: g = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
      6'd26: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7f};
      6'd27: g = {8'h5e, 8'h21, 8'h51, 8'h41, 8'h3e};
      6'd28: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7f};
      6'd29: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      6'd30: g = {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
      6'd31: g = {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
      6'd32: g = {8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f};
      6'd33: g = {8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f};
      6'd34: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd35: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd36: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      6'd37: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      6'd38: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      6'd39: g = {8'h08, 8'h08, 8'h3e, 8'h08, 8'h08};
      default: g = 40'd0;
    endcase
    return g;
  endfunction

  // column select, the sixth column is the blank spacer
  function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = g[7:0];
      3'd1: c = g[15:8];
      3'd2: c = g[23:16];
      3'd3: c = g[31:24];
      3'd4: c = g[39:32];
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rgfd_req_if.sv =====
// ----------------------------------------------------------------------------
// rgfd_req_if
// Valid/ready command channel of the glyph drawer.
// ----------------------------------------------------------------------------
interface rgfd_req_if import rgfd_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rgfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rgfd_rsp_if
// Valid/ready result channel of the glyph drawer.
// ----------------------------------------------------------------------------
interface rgfd_rsp_if import rgfd_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rgfd_ram.sv =====
// ----------------------------------------------------------------------------
// rgfd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rgfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rgfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgfd_ctrl
// Command sequencer: decodes a transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module rgfd_ctrl import rgfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [2:0] req_cmd,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_INIT: begin
        ctl.clr_step = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          priority case (req_cmd)
            CMD_CLEAR: state_next = ST_CLR;
            CMD_PIXEL, CMD_RECT, CMD_VCHAR: state_next = ST_WALK;
            CMD_PCHAR: state_next = ST_PAGE;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_CLR: begin
        ctl.clr_step = 1'b1;
        if (status.clr_last) state_next = ST_FINISH;
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_next = ST_FINISH;
        end else if (status.walk_need) begin
          ctl.walk_read = 1'b1;
          state_next    = ST_MODIFY;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      ST_MODIFY: begin
        ctl.walk_write = 1'b1;
        ctl.walk_step  = 1'b1;
        state_next     = ST_WALK;
      end
      ST_PAGE: begin
        if (!status.page_fit) begin
          state_next = ST_FINISH;
        end else begin
          ctl.page_write = 1'b1;
          if (status.page_last) state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        ctl.read_issue = 1'b1;
        state_next     = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        ctl.read_capture = 1'b1;
        state_next       = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.slot_free) begin
          ctl.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end
endmodule

// ===== rtl/rgfd_dp.sv =====
// ----------------------------------------------------------------------------
// rgfd_dp
// Datapath: operand registers, pixel walker, frame store and result register.
// ----------------------------------------------------------------------------
module rgfd_dp import rgfd_pkg::*; #(
  parameter int VIEW_WIDTH  = 64,
  parameter int VIEW_HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  req_item_t  req_data,
  input  dp_cmd_t    ctl,
  output dp_status_t status,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  output rsp_item_t  rsp_data
);
  localparam logic [8:0]  VW9  = 9'(VIEW_WIDTH);
  localparam logic [8:0]  VH9  = 9'(VIEW_HEIGHT);
  localparam logic [10:0] VW11 = 11'(VIEW_WIDTH);

  // operands
  logic [2:0]  kind;
  logic [7:0]  px, py, xend, yend, sc, pg, cl;
  logic        ink;
  logic [39:0] glyph;
  logic        gfit, pfit, rd_ok;
  logic        fitted;
  logic [7:0]  next_pos, read_data;

  // walker
  logic [7:0]  rx, ry, xb, yb, dx, dy;
  logic [2:0]  gc, gr, pi;
  logic        one_done;
  logic [ADDR_W-1:0] clr_cnt;

  logic [7:0]  pt_x, pt_y, col_bits, mask, rdata, wdata;
  logic        on_bit, in_view, row_ok, col_ok, inner_last;
  logic [ADDR_W-1:0] pt_addr, pg_addr, rd_addr, waddr;
  logic        we, re;
  logic [10:0] span5;
  logic [7:0]  sc6;

  assign span5 = 11'({req_data.scale, 2'b00}) + 11'(req_data.scale) + 11'(req_data.pos_x);
  assign sc6   = 8'({req_data.scale, 2'b00}) + 8'({req_data.scale, 1'b0});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind  <= req_data.cmd;
      px    <= req_data.pos_x;
      py    <= req_data.pos_y;
      xend  <= req_data.pos_x + req_data.rect_width;
      yend  <= req_data.pos_y + req_data.rect_height;
      ink   <= req_data.ink_on;
      sc    <= req_data.scale;
      pg    <= req_data.page;
      cl    <= req_data.column;
      glyph <= glyph_row(rom_slot(req_data.char_code));
      gfit  <= (req_data.scale != 8'd0) && (span5 <= VW11);
      pfit  <= (req_data.page < 8'(PANEL_PAGES)) &&
               (9'(req_data.column) + 9'(GLYPH_COLS) < 9'(PANEL_COLUMNS));
      rd_ok <= (req_data.page < 8'(PANEL_PAGES)) && (req_data.column < 8'(PANEL_COLUMNS));
      read_data <= 8'd0;
      if (req_data.cmd == CMD_VCHAR) begin
        fitted   <= (req_data.scale != 8'd0) && (span5 <= VW11);
        next_pos <= ((req_data.scale != 8'd0) && (span5 <= VW11)) ?
                    req_data.pos_x + sc6 : req_data.pos_x;
      end else if (req_data.cmd == CMD_PCHAR) begin
        fitted   <= (req_data.page < 8'(PANEL_PAGES)) &&
                    (9'(req_data.column) + 9'(GLYPH_COLS) < 9'(PANEL_COLUMNS));
        next_pos <= ((req_data.page < 8'(PANEL_PAGES)) &&
                    (9'(req_data.column) + 9'(GLYPH_COLS) < 9'(PANEL_COLUMNS))) ?
                    req_data.column + 8'(GLYPH_PITCH) : req_data.column;
      end else begin
        fitted   <= 1'b0;
        next_pos <= 8'd0;
      end
    end else if (ctl.read_capture) begin
      read_data <= rd_ok ? rdata : 8'd0;
    end
  end

  // current point of the walk
  assign pt_x     = (kind == CMD_VCHAR) ? xb + dx : rx;
  assign pt_y     = (kind == CMD_VCHAR) ? yb + dy : ry;
  assign col_bits = glyph_col(glyph, gc);
  assign on_bit   = (kind == CMD_VCHAR) ? col_bits[gr] : 1'b1;
  assign in_view  = ({1'b0, pt_x} < VW9) && ({1'b0, pt_y} < VH9);
  assign row_ok   = ({1'b0, ry} < VH9) && (ry < yend);
  assign col_ok   = ({1'b0, rx} < VW9) && (rx < xend);
  assign inner_last = (dx == sc - 8'd1) && (dy == sc - 8'd1);

  always_comb begin
    unique case (kind)
      CMD_PIXEL: status.walk_done = one_done;
      CMD_RECT:  status.walk_done = !(row_ok && col_ok);
      CMD_VCHAR: status.walk_done = !gfit || (gc == GLYPH_COLS);
      default:   status.walk_done = 1'b1;
    endcase
  end

  assign status.walk_need  = on_bit && in_view;
  assign status.kind       = kind;
  assign status.clr_last   = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
  assign status.page_fit   = pfit;
  assign status.page_last  = (pi == GLYPH_PITCH - 3'd1);
  assign status.slot_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rx <= req_data.pos_x;
      ry <= req_data.pos_y;
      xb <= req_data.pos_x;
      yb <= req_data.pos_y;
      dx <= 8'd0;
      dy <= 8'd0;
      gc <= 3'd0;
      gr <= 3'd0;
      pi <= 3'd0;
      one_done <= 1'b0;
    end else if (ctl.walk_step) begin
      one_done <= 1'b1;
      if (kind == CMD_RECT) begin
        if (({1'b0, rx} + 9'd1 < VW9) && (rx + 8'd1 < xend)) begin
          rx <= rx + 8'd1;
        end else begin
          rx <= px;
          ry <= ry + 8'd1;
        end
      end else if (kind == CMD_VCHAR) begin
        // scale x scale block per lit glyph pixel, then the next glyph cell
        if (on_bit && !inner_last) begin
          if (dy == sc - 8'd1) begin
            dy <= 8'd0;
            dx <= dx + 8'd1;
          end else begin
            dy <= dy + 8'd1;
          end
        end else begin
          dx <= 8'd0;
          dy <= 8'd0;
          if (gr == GLYPH_ROWS - 3'd1) begin
            gr <= 3'd0;
            yb <= py;
            gc <= gc + 3'd1;
            xb <= xb + sc;
          end else begin
            gr <= gr + 3'd1;
            yb <= yb + sc;
          end
        end
      end
    end else if (ctl.page_write) begin
      pi <= pi + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (ctl.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  // rotated view: column is PANEL_COLUMNS-1-y, page x/8, bit x%8
  assign pt_addr = {pt_x[5:3], ~pt_y[COL_W-1:0]};
  assign pg_addr = {pg[PAGE_W-1:0], cl[COL_W-1:0] + COL_W'(pi)};
  assign rd_addr = (kind == CMD_READ) ? {pg[PAGE_W-1:0], cl[COL_W-1:0]} : pt_addr;
  assign mask    = 8'd1 << pt_x[2:0];
  assign re      = ctl.walk_read || ctl.read_issue;

  always_comb begin
    we    = 1'b1;
    waddr = pt_addr;
    wdata = ink ? (rdata | mask) : (rdata & ~mask);
    priority if (ctl.clr_step) begin
      waddr = clr_cnt;
      wdata = 8'd0;
    end else if (ctl.page_write) begin
      waddr = pg_addr;
      wdata = glyph_col(glyph, pi);
    end else begin
      we = ctl.walk_write;
    end
  end

  rgfd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (ctl.res_load) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      rsp_data.read_data <= read_data;
      rsp_data.fitted    <= fitted;
      rsp_data.next_pos  <= next_pos;
    end
  end
endmodule

// ===== rtl/rotated_glyph_framebuffer_drawer.sv =====
// ----------------------------------------------------------------------------
// rotated_glyph_framebuffer_drawer
// Drawing engine over a 128 x 8-page monochrome frame store, rotated view.
// ----------------------------------------------------------------------------
// usage: commands arrive on req (valid/ready), one result per command leaves
// on rsp (valid/ready). a transaction on req is taken only while the engine is
// idle; the finished result sits in an output register, so the next command
// is accepted while rsp is stalled, and that command waits at its end for the
// register to free up.
// work per command is set by the single read/write port pair of the store:
//   clear writes one byte per cycle; read byte issues a read and then
//   captures it; page char writes five glyph columns and a blank spacer,
//   and nothing when it does not fit; pixel, fill rect and view char visit
//   each pixel, view char skipping blank glyph cells and each lit cell being
//   scale^2 pixels; clipped pixels are passed over, and a view char that
//   does not fit draws nothing.
// every drawn pixel is a read-modify-write of its byte.
// after reset the store is swept to zero, with req.ready low.
// ----------------------------------------------------------------------------
module rotated_glyph_framebuffer_drawer import rgfd_pkg::*; #(
  parameter int VIEW_WIDTH  = 64,
  parameter int VIEW_HEIGHT = 128
) (
  input logic clk,
  input logic rst,
  rgfd_req_if.sink   req,
  rgfd_rsp_if.source rsp
);
  dp_cmd_t    ctl;
  dp_status_t status;

  rgfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.data.cmd),
    .req_ready (req.ready),
    .status    (status),
    .ctl       (ctl)
  );

  rgfd_dp #(.VIEW_WIDTH(VIEW_WIDTH), .VIEW_HEIGHT(VIEW_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .ctl       (ctl),
    .status    (status),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_data  (rsp.data)
  );
endmodule

// ===== tb/tb_rotated_glyph_framebuffer_drawer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotated_glyph_framebuffer_drawer
// Self-checking bench for the rotated glyph drawer.
// A shadow frame store predicts every result. Commands are sent in bursts
// with random gaps, and the result side stalls at random. Directed corner
// commands come first, then about 1150 random ones.
// ----------------------------------------------------------------------------
module tb_rotated_glyph_framebuffer_drawer;
  import rgfd_pkg::*;

  localparam int VIEW_W = 64;
  localparam int VIEW_H = 128;
  localparam int N_RANDOM = 1150;
  localparam int CYCLE_LIMIT = 3000000;

  // glyph columns, bit 0 at the top
  localparam logic [7:0] FONT [40][5] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h3e,8'h51,8'h49,8'h45,8'h3e},
    '{8'h00,8'h42,8'h7f,8'h40,8'h00}, '{8'h42,8'h61,8'h51,8'h49,8'h46},
    '{8'h21,8'h41,8'h45,8'h4b,8'h31}, '{8'h18,8'h14,8'h12,8'h7f,8'h10},
    '{8'h27,8'h45,8'h45,8'h45,8'h39}, '{8'h3c,8'h4a,8'h49,8'h49,8'h30},
    '{8'h01,8'h71,8'h09,8'h05,8'h03}, '{8'h36,8'h49,8'h49,8'h49,8'h36},
    '{8'h06,8'h49,8'h49,8'h29,8'h1e}, '{8'h7e,8'h11,8'h11,8'h11,8'h7e},
    '{8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h3e,8'h41,8'h41,8'h41,8'h22},
    '{8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h7f,8'h49,8'h49,8'h49,8'h41},
    '{8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h3e,8'h41,8'h49,8'h49,8'h7a},
    '{8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h41,8'h7f,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h7f,8'h08,8'h14,8'h22,8'h41},
    '{8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
    '{8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h3e,8'h41,8'h41,8'h41,8'h3e},
    '{8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h3e,8'h41,8'h51,8'h21,8'h5e},
    '{8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h3f,8'h40,8'h40,8'h40,8'h3f},
    '{8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h3f,8'h40,8'h38,8'h40,8'h3f},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h08,8'h08,8'h3e,8'h08,8'h08}
  };

  class draw_scoreboard;
    logic [7:0] shadow [PANEL_COLUMNS * PANEL_PAGES];
    rsp_item_t  due_q [$];
    int         errors;

    function new();
      foreach (shadow[i]) shadow[i] = 8'd0;
      errors = 0;
    endfunction

    function int font_index(logic [7:0] code);
      if (code >= "0" && code <= "9") return 1 + (code - "0");
      if (code >= "A" && code <= "Z") return 11 + (code - "A");
      if (code == "-") return 37;
      if (code == ".") return 38;
      if (code == "+") return 39;
      return 0;
    endfunction

    function void plot(int x, int y, logic on);
      int idx;
      if (x >= VIEW_W || y >= VIEW_H) return;
      idx = (x >> 3) * PANEL_COLUMNS + (PANEL_COLUMNS - 1 - y);
      if (on) shadow[idx][x & 7] = 1'b1;
      else shadow[idx][x & 7] = 1'b0;
    endfunction

    function void note_input(req_item_t it);
      rsp_item_t r;
      int g, xe, ye, sc, px, py, base;
      r = '0;
      px = it.pos_x;
      py = it.pos_y;
      sc = it.scale;
      case (it.cmd)
        CMD_CLEAR: foreach (shadow[i]) shadow[i] = 8'd0;
        CMD_PIXEL: plot(px, py, it.ink_on);
        CMD_RECT: begin
          ye = (py + it.rect_height) & 255;
          xe = (px + it.rect_width) & 255;
          for (int y = py; y < VIEW_H && y < ye; y++)
            for (int x = px; x < VIEW_W && x < xe; x++) plot(x, y, it.ink_on);
        end
        CMD_VCHAR: begin
          r.next_pos = it.pos_x;
          if (sc != 0 && px + 5 * sc <= VIEW_W) begin
            g = font_index(it.char_code);
            for (int c = 0; c < 5; c++)
              for (int rw = 0; rw < 7; rw++)
                if (FONT[g][c][rw])
                  for (int dx = 0; dx < sc; dx++)
                    for (int dy = 0; dy < sc; dy++)
                      plot((px + c * sc + dx) & 255, (py + rw * sc + dy) & 255, it.ink_on);
            r.fitted = 1'b1;
            r.next_pos = 8'(px + 6 * sc);
          end
        end
        CMD_PCHAR: begin
          r.next_pos = it.column;
          if (it.page < PANEL_PAGES && it.column + 5 < PANEL_COLUMNS) begin
            g = font_index(it.char_code);
            base = it.page * PANEL_COLUMNS + it.column;
            for (int i = 0; i < 5; i++) shadow[base + i] = FONT[g][i];
            shadow[base + 5] = 8'd0;
            r.fitted = 1'b1;
            r.next_pos = 8'(it.column + 6);
          end
        end
        CMD_READ: begin
          if (it.page < PANEL_PAGES && it.column < PANEL_COLUMNS)
            r.read_data = shadow[it.page * PANEL_COLUMNS + it.column];
        end
        default: ;
      endcase
      due_q.push_back(r);
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.fitted !== want.fitted) begin
        $display("%0t: fitted expected %b actual %b", $time, want.fitted, got.fitted);
        errors++;
      end
      if (got.next_pos !== want.next_pos) begin
        $display("%0t: next_pos expected %h actual %h", $time, want.next_pos, got.next_pos);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  rgfd_req_if req ();
  rgfd_rsp_if rsp ();

  rotated_glyph_framebuffer_drawer #(.VIEW_WIDTH(VIEW_W), .VIEW_HEIGHT(VIEW_H)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  draw_scoreboard sb = new();
  int sent;
  int cmd_seen [8];
  int burst_left;
  int cycles;
  int hold_left;
  bit hold_done;
  int ready_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      ready_pct <= 100;
    end else begin
      if (cycles % 128 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && sent >= 300) begin
        rsp.ready <= 1'b0;
        hold_left <= 3000;
        hold_done <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
      if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_cmd(req_item_t it);
    bit took;
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.data <= it;
    // ready is settled mid-cycle, so sample it there for the coming edge
    do begin
      @(negedge clk);
      took = req.ready;
      @(posedge clk);
    end while (!took);
    sb.note_input(it);
    cmd_seen[it.cmd]++;
    sent++;
  endtask

  function automatic req_item_t mk(logic [2:0] cmd, int x, int y, int w, int h, logic on,
                                   logic [7:0] code, int sc, int pg, int col);
    req_item_t it;
    it.cmd = cmd;
    it.pos_x = 8'(x);
    it.pos_y = 8'(y);
    it.rect_width = 8'(w);
    it.rect_height = 8'(h);
    it.ink_on = on;
    it.char_code = code;
    it.scale = 8'(sc);
    it.page = 8'(pg);
    it.column = 8'(col);
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range("0", "9"));
      2, 3, 4, 5: return 8'($urandom_range("A", "Z"));
      6: return "-";
      7: return ".";
      8: return "+";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic req_item_t random_cmd();
    req_item_t it;
    logic [95:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(req_item_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 2) it.cmd = CMD_CLEAR;
    else if (k < 27) it.cmd = CMD_PIXEL;
    else if (k < 42) it.cmd = CMD_RECT;
    else if (k < 62) it.cmd = CMD_VCHAR;
    else if (k < 75) it.cmd = CMD_PCHAR;
    else if (k < 95) it.cmd = CMD_READ;
    else it.cmd = 3'($urandom_range(6, 7));
    case (it.cmd)
      CMD_PIXEL: if ($urandom_range(0, 9) < 8) begin
        it.pos_x = 8'($urandom_range(0, VIEW_W - 1));
        it.pos_y = 8'($urandom_range(0, VIEW_H - 1));
      end
      CMD_RECT: begin
        if ($urandom_range(0, 9) < 8) it.pos_x = 8'($urandom_range(0, VIEW_W - 1));
        if ($urandom_range(0, 9) < 8) it.pos_y = 8'($urandom_range(0, VIEW_H - 1));
        // keep most fills small, the odd one runs to the full wrap range
        if ($urandom_range(0, 19) != 0) begin
          it.rect_width = 8'($urandom_range(0, 16));
          it.rect_height = 8'($urandom_range(0, 16));
        end
      end
      CMD_VCHAR: begin
        it.char_code = pick_char();
        k = $urandom_range(0, 19);
        if (k < 17) it.scale = 8'($urandom_range(1, 3));
        else if (k == 17) it.scale = 8'd0;
        if ($urandom_range(0, 9) < 8) it.pos_x = 8'($urandom_range(0, VIEW_W - 1));
      end
      CMD_PCHAR: begin
        it.char_code = pick_char();
        if ($urandom_range(0, 9) < 8) it.page = 8'($urandom_range(0, PANEL_PAGES - 1));
        if ($urandom_range(0, 9) < 8) it.column = 8'($urandom_range(0, PANEL_COLUMNS - 1));
      end
      CMD_READ: begin
        if ($urandom_range(0, 9) < 8) it.page = 8'($urandom_range(0, PANEL_PAGES - 1));
        if ($urandom_range(0, 9) < 8) it.column = 8'($urandom_range(0, PANEL_COLUMNS - 1));
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.data <= '0;
    sent = 0;
    burst_left = 0;
    cycles = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_cmd(mk(CMD_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_PIXEL, 63, 127, 0, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_PIXEL, 64, 0, 0, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_PIXEL, 0, 128, 0, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_PIXEL, 255, 255, 255, 255, 1, 255, 255, 255, 255));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 127));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 7, 0));
    send_cmd(mk(CMD_RECT, 250, 0, 10, 5, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_RECT, 0, 0, 64, 128, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_RECT, 60, 120, 255, 255, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 3, 5));
    send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_VCHAR, 10, 10, 0, 0, 1, "A", 0, 0, 0));
    send_cmd(mk(CMD_VCHAR, 59, 0, 0, 0, 1, "8", 1, 0, 0));
    send_cmd(mk(CMD_VCHAR, 60, 0, 0, 0, 1, "8", 1, 0, 0));
    send_cmd(mk(CMD_VCHAR, 4, 250, 0, 0, 1, "+", 12, 0, 0));
    send_cmd(mk(CMD_VCHAR, 0, 124, 0, 0, 0, "W", 2, 0, 0));
    send_cmd(mk(CMD_PCHAR, 0, 0, 0, 0, 0, "Z", 0, 7, 122));
    send_cmd(mk(CMD_PCHAR, 0, 0, 0, 0, 0, ".", 0, 0, 123));
    send_cmd(mk(CMD_PCHAR, 0, 0, 0, 0, 0, "-", 0, 8, 0));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 7, 124));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 8, 0));
    send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 128));
    send_cmd(mk(3'd6, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_cmd(mk(3'd7, 1, 1, 1, 1, 1, 1, 1, 1, 1));

    repeat (N_RANDOM) send_cmd(random_cmd());
    req.valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d commands: clear %0d pixel %0d rect %0d vchar %0d pchar %0d read %0d",
             sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
             cmd_seen[5]);
    $display("unused codes %0d, mismatches %0d", cmd_seen[6] + cmd_seen[7], sb.errors);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
